// File: rtl/core/wfc_pkg.sv
// Shared constants, types and state codes for the word frequency counter.
`default_nettype none

package wfc_pkg;

  // Default sizing of the table, the word buffer and the counters
  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned MaxWordCharsDef = 16;
  localparam int unsigned CountBitsDef    = 16;

  // Byte codes and fixed field widths
  localparam int unsigned CharW     = 8;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned OutCountW = 16;
  localparam logic [CharW-1:0] SepCode = 8'd32;
  localparam logic [CharW-1:0] EndCode = 8'd0;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_e;

  // Control of the pending word buffer
  typedef struct packed {
    logic push;   // append the current byte
    logic clear;  // word finished, start a new one
  } wbuf_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/word_frequency_counter.sv
// Word frequency counter: byte stream in, one table update result per word out.
//
// Input stream s_axis carries one text byte per request. A space ends a word,
// a zero byte ends the text and any pending word; other bytes build the word
// (bytes past MAX_WORD_CHARS are dropped). Each finished non-empty word yields
// one request on m_axis: slot and new count in tdata, is_new and dropped in
// tuser. Empty words give nothing.
// Word bytes are taken while the block is idle. A terminating byte that ends a
// non-empty word starts a lookup: the compare unit visits the stored entries
// in order (one table row read per cycle) until the found entry or all used
// entries, then the result is handed to the output register and the block is
// ready again. With an empty table the scan is skipped. s_axis_tready is low
// while a word is being looked up or while its result waits to be handed on.
// Reset clears the pending word and the table fill count; counts then
// accumulate across texts until the next reset.
// A stalled receiver holds the result in the output register; the block still
// takes word bytes, and a following finished word waits for that register.
`default_nettype none

module word_frequency_counter
  import wfc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES  = TableEntriesDef,
  parameter int unsigned MAX_WORD_CHARS = MaxWordCharsDef,
  parameter int unsigned COUNT_BITS     = CountBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,   // [3:0] slot, [19:4] new_count, [23:20] zero
  output logic      [1:0]  m_axis_tuser    // [0] is_new, [1] dropped
);

  localparam int unsigned LenW   = $clog2(MAX_WORD_CHARS + 1);
  localparam int unsigned WordW  = MAX_WORD_CHARS * CharW;
  localparam int unsigned IdxW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned UsedW  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned RowW   = COUNT_BITS + LenW + WordW;
  localparam int unsigned SlotXW = (IdxW > SlotW) ? IdxW : SlotW;
  localparam int unsigned CntXW  = (COUNT_BITS > OutCountW) ? COUNT_BITS : OutCountW;

  state_e state_q, state_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [UsedW-1:0] used_q, used_d;

  logic                  res_new_q, res_new_d, res_drop_q, res_drop_d;
  logic [SlotW-1:0]      res_slot_q, res_slot_d;
  logic [OutCountW-1:0]  res_count_q, res_count_d;
  logic                  res_load;

  logic                  m_valid_q, m_load;
  logic [SlotW-1:0]      m_slot_q;
  logic [OutCountW-1:0]  m_count_q;
  logic                  m_new_q, m_drop_q;

  wbuf_ctrl_t       wb_ctrl;
  logic [WordW-1:0] cur_word;
  logic [LenW-1:0]  cur_len;

  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr, mem_raddr;
  logic [RowW-1:0]  mem_wdata, mem_rdata;

  logic [COUNT_BITS-1:0] rd_count, count_inc;
  logic [LenW-1:0]       rd_len;
  logic [WordW-1:0]      rd_word;
  logic                  hit, is_last, full, in_fire, is_term, word_done;
  logic                  hit_now, miss_now;
  logic [SlotXW-1:0]     slot_x;
  logic [CntXW-1:0]      count_x;

  // Submodules
  wfc_word_buf #(
    .MAX_WORD_CHARS(MAX_WORD_CHARS)
  ) u_word_buf (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(wb_ctrl),
    .char_i(s_axis_tdata),
    .word_o(cur_word),
    .len_o (cur_len)
  );

  wfc_entry_mem #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .ROW_W        (RowW)
  ) u_entry_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  wfc_cmp #(
    .MAX_WORD_CHARS(MAX_WORD_CHARS)
  ) u_cmp (
    .word_a_i(cur_word),
    .len_a_i (cur_len),
    .word_b_i(rd_word),
    .len_b_i (rd_len),
    .match_o (hit)
  );

  // Row fields of the entry under compare
  assign rd_count = mem_rdata[RowW-1 -: COUNT_BITS];
  assign rd_len   = mem_rdata[WordW +: LenW];
  assign rd_word  = mem_rdata[WordW-1:0];

  // Saturating increment
  assign count_inc = (&rd_count) ? rd_count : rd_count + COUNT_BITS'(1);

  // Input decode and table status
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign is_term   = (s_axis_tdata == SepCode) || (s_axis_tdata == EndCode);
  assign word_done = in_fire && is_term && (cur_len != '0);
  assign is_last   = (UsedW'(idx_q) + UsedW'(1)) == used_q;
  assign full      = used_q == UsedW'(TABLE_ENTRIES);

  assign hit_now  = (state_q == ST_SCAN) && hit;
  assign miss_now = ((state_q == ST_IDLE) && word_done && (used_q == '0)) ||
                    ((state_q == ST_SCAN) && !hit && is_last);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (word_done) begin
          state_d = (used_q == '0) ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || is_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    wb_ctrl.push  = (state_q == ST_IDLE) && in_fire && !is_term;
    wb_ctrl.clear = hit_now || miss_now;
    m_load        = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

    mem_raddr = (state_q == ST_SCAN) ? idx_q + IdxW'(1) : '0;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = {count_inc, rd_len, rd_word};

    idx_d    = (state_q == ST_SCAN) ? idx_q + IdxW'(1) : '0;
    used_d   = used_q;
    res_load = 1'b0;
    slot_x   = '0;
    count_x  = '0;
    res_new_d  = 1'b0;
    res_drop_d = 1'b0;

    if (hit_now) begin
      // Found: bump the entry count in place
      mem_we   = 1'b1;
      res_load = 1'b1;
      slot_x   = SlotXW'(idx_q);
      count_x  = CntXW'(count_inc);
    end else if (miss_now) begin
      res_load = 1'b1;
      if (!full) begin
        // New entry at the next free row
        mem_we     = 1'b1;
        mem_waddr  = used_q[IdxW-1:0];
        mem_wdata  = {COUNT_BITS'(1), cur_len, cur_word};
        used_d     = used_q + UsedW'(1);
        slot_x     = SlotXW'(used_q[IdxW-1:0]);
        count_x    = CntXW'(1);
        res_new_d  = 1'b1;
      end else begin
        res_drop_d = 1'b1;
      end
    end

    res_slot_d  = slot_x[SlotW-1:0];
    res_count_d = count_x[OutCountW-1:0];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      used_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      used_q  <= used_d;
      if (m_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Result and output payload registers
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_slot_q  <= res_slot_d;
      res_count_q <= res_count_d;
      res_new_q   <= res_new_d;
      res_drop_q  <= res_drop_d;
    end
    if (m_load) begin
      m_slot_q  <= res_slot_q;
      m_count_q <= res_count_q;
      m_new_q   <= res_new_q;
      m_drop_q  <= res_drop_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, m_count_q, m_slot_q};
  assign m_axis_tuser  = {m_drop_q, m_new_q};

endmodule

`default_nettype wire

// File: rtl/core/wfc_word_buf.sv
// Pending word buffer: collects word characters and tracks the word length.
`default_nettype none

module wfc_word_buf
  import wfc_pkg::*;
#(
  parameter int unsigned MAX_WORD_CHARS = MaxWordCharsDef,
  localparam int unsigned LenW   = $clog2(MAX_WORD_CHARS + 1),
  localparam int unsigned WordW  = MAX_WORD_CHARS * CharW,
  localparam int unsigned CharIdxW = $clog2(MAX_WORD_CHARS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wbuf_ctrl_t        ctrl_i,
  input  wire logic [CharW-1:0]  char_i,
  output logic      [WordW-1:0]  word_o,
  output logic      [LenW-1:0]   len_o
);

  logic [CharW-1:0] buf_q [MAX_WORD_CHARS];
  logic [LenW-1:0]  len_q, len_d;
  logic             room;

  // Characters past the buffer size are dropped
  assign room = len_q < LenW'(MAX_WORD_CHARS);

  always_comb begin
    len_d = len_q;
    if (ctrl_i.clear) begin
      len_d = '0;
    end else if (ctrl_i.push && room) begin
      len_d = len_q + LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  // Character storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && room) begin
      buf_q[len_q[CharIdxW-1:0]] <= char_i;
    end
  end

  for (genvar i = 0; i < MAX_WORD_CHARS; i++) begin : g_pack
    assign word_o[i*CharW +: CharW] = buf_q[i];
  end

  assign len_o = len_q;

endmodule

`default_nettype wire

// File: rtl/core/wfc_cmp.sv
// Word compare unit: equal length and equal characters up to that length.
`default_nettype none

module wfc_cmp
  import wfc_pkg::*;
#(
  parameter int unsigned MAX_WORD_CHARS = MaxWordCharsDef,
  localparam int unsigned LenW  = $clog2(MAX_WORD_CHARS + 1),
  localparam int unsigned WordW = MAX_WORD_CHARS * CharW
) (
  input  wire logic [WordW-1:0] word_a_i,
  input  wire logic [LenW-1:0]  len_a_i,
  input  wire logic [WordW-1:0] word_b_i,
  input  wire logic [LenW-1:0]  len_b_i,
  output logic                  match_o
);

  logic [MAX_WORD_CHARS-1:0] char_ok;

  // Positions beyond the word length are don't-care
  for (genvar i = 0; i < MAX_WORD_CHARS; i++) begin : g_char
    assign char_ok[i] = (LenW'(i) >= len_a_i) ||
                        (word_a_i[i*CharW +: CharW] == word_b_i[i*CharW +: CharW]);
  end

  assign match_o = (len_a_i == len_b_i) && (&char_ok);

endmodule

`default_nettype wire

// File: rtl/core/wfc_entry_mem.sv
// Table memory: one row per entry holding count, length and characters.
`default_nettype none

module wfc_entry_mem
  import wfc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned ROW_W         = 16,
  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IdxW-1:0]  waddr_i,
  input  wire logic [ROW_W-1:0] wdata_i,
  input  wire logic [IdxW-1:0]  raddr_i,
  output logic      [ROW_W-1:0] rdata_o
);

  logic [ROW_W-1:0] mem_q [TABLE_ENTRIES];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
